// ===== src/mfml_pkg.sv =====
// Shared types and constants for the management frame monitor and logger.
// No dependencies.
`timescale 1ns / 1ps

package mfml_pkg;

   // Counter width; results show the low 32 bits
   localparam int COUNT_BITS = 32;

   localparam int LOG_BITS          = 25;
   localparam int PCAP_FILE_HEADER  = 24;
   localparam int PCAP_RECORD_HDR   = 16;

   localparam logic [LOG_BITS-1:0] LOG_LIMIT_RESET = 25'd16777216;
   localparam logic [19:0]         ALERT_WINDOW_RESET = 20'd8000;
   localparam logic [7:0]          SNAP_LENGTH_RESET = 8'd128;

   // now / 1000 as (now * MS_RECIP) >> MS_SHIFT, exact over 32 bits
   localparam logic [31:0] MS_RECIP = 32'h10624DD3;
   localparam int          MS_SHIFT = 38;

   typedef enum logic [1:0] {
      CSR_ALERT_WINDOW = 2'd0,
      CSR_SNAP_LENGTH  = 2'd1,
      CSR_LOG_LIMIT    = 2'd2,
      CSR_LOG_READY    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_NONE       = 3'd0,
      KIND_BEACON     = 3'd1,
      KIND_PROBE_REQ  = 3'd2,
      KIND_PROBE_RESP = 3'd3,
      KIND_DEAUTH     = 3'd4
   } frame_kind_type;

   typedef enum logic [1:0] {
      LOG_NOT_READY = 2'd0,
      LOG_ACTIVE    = 2'd1,
      LOG_STOPPED   = 2'd2
   } log_status_type;

   typedef enum logic [0:0] {
      OP_FRAME = 1'b0,
      OP_QUERY = 1'b1
   } operation_type;

   localparam logic [1:0] FC_TYPE_MGMT     = 2'd0;
   localparam logic [3:0] SUBTYPE_BEACON   = 4'd8;
   localparam logic [3:0] SUBTYPE_PROBE_RQ = 4'd4;
   localparam logic [3:0] SUBTYPE_PROBE_RS = 4'd5;
   localparam logic [3:0] SUBTYPE_DEAUTH   = 4'd12;

endpackage

// ===== src/mgmt_frame_monitor_logger.sv =====
// Management frame monitor and logger: classifier, counters, alert and log size.
// Depends on mfml_pkg.
`timescale 1ns / 1ps

// Usage
//  req_* : one item per handshake, a frame descriptor (operation 0) or a
//          time-only status query (operation 1). Accepted when req_valid and
//          req_ready are both high.
//  rsp_* : one result item per request item, in order, valid/ready.
//  csr_* : plain write port; csr_index selects alert window, snap length,
//          log limit or log ready. Write only while no item is in flight.
//  Pipeline: input register (now / 1000 quotient taken there through one
//  32x32 reciprocal multiply) then result register, where classification,
//  counters, alert and log size are settled. rsp_valid rises as the item
//  moves into the result register; one item per cycle sustained while rsp_ready
//  holds, the state update being a single step at that move.
//  Receiver stall: the result register holds, the input register still
//  takes one more item, then req_ready drops until rsp_ready returns.
//  Reset (synchronous): pipeline empty, counters and last deauth time zero,
//  log size 24 (pcap file header), logging not stopped, registers at reset.
//  No clearing pass is needed; the block is ready the cycle after reset.

module mgmt_frame_monitor_logger (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_write_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic        req_is_management,
   input  logic [15:0] req_frame_control,
   input  logic [11:0] req_frame_length,
   input  logic [31:0] req_now_ms,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_recorded,
   output logic [2:0]  rsp_frame_kind,
   output logic [7:0]  rsp_captured_length,
   output logic [22:0] rsp_ts_seconds,
   output logic [19:0] rsp_ts_micros,
   output logic [31:0] rsp_beacon_total,
   output logic [31:0] rsp_probe_total,
   output logic [31:0] rsp_deauth_total,
   output logic        rsp_alert_active,
   output logic        rsp_log_written,
   output logic [1:0]  rsp_log_status
);

   localparam int CB = mfml_pkg::COUNT_BITS;
   localparam int LB = mfml_pkg::LOG_BITS;

   // configuration
   logic [19:0]   alert_window_ff;
   logic [7:0]    snap_length_ff;
   logic [LB-1:0] log_limit_ff;
   logic          log_ready_ff;

   // state
   logic [CB-1:0] beacons_ff, beacons_in;
   logic [CB-1:0] probes_ff, probes_in;
   logic [CB-1:0] deauths_ff, deauths_in;
   logic [31:0]   last_deauth_ff, last_deauth_in;
   logic [LB-1:0] log_size_ff, log_size_in;
   logic          log_stopped_ff, log_stopped_in;

   // input stage
   logic          a_valid_ff;
   logic          a_op_ff;
   logic          a_mgmt_ff;
   logic [15:0]   a_fc_ff;
   logic [11:0]   a_flen_ff;
   logic [31:0]   a_now_ff;
   logic [22:0]   a_secs_ff;

   // result stage
   logic          b_valid_ff;
   logic          b_recorded_ff;
   logic [2:0]    b_kind_ff;
   logic [7:0]    b_cap_ff;
   logic [22:0]   b_secs_ff;
   logic [19:0]   b_micros_ff;
   logic          b_alert_ff;
   logic          b_written_ff;
   logic [1:0]    b_status_ff;

   logic          a_load;
   logic          move;
   logic          b_free;
   logic [63:0]   recip_product;

   mfml_pkg::frame_kind_type kind_in;
   logic [7:0]    cap_in;
   logic          written_in;
   logic          alert_in;
   logic [1:0]    status_in;
   logic [19:0]   micros_in;
   logic [31:0]   q_times_1000;
   logic [9:0]    rem_ms;
   logic [LB:0]   grown;
   logic [31:0]   since_deauth;

   // handshake
   assign b_free    = !b_valid_ff || rsp_ready;
   assign move      = a_valid_ff && b_free;
   assign req_ready = !a_valid_ff || b_free;
   assign a_load    = req_valid && req_ready;

   // seconds through the reciprocal, registered with the item
   assign recip_product = 64'(req_now_ms) * 64'(mfml_pkg::MS_RECIP);

   always_comb begin
      kind_in        = mfml_pkg::KIND_NONE;
      cap_in         = '0;
      written_in     = 1'b0;
      beacons_in     = beacons_ff;
      probes_in      = probes_ff;
      deauths_in     = deauths_ff;
      last_deauth_in = last_deauth_ff;
      log_size_in    = log_size_ff;
      log_stopped_in = log_stopped_ff;

      if (a_op_ff == mfml_pkg::OP_FRAME && a_mgmt_ff && a_flen_ff >= 12'd2 &&
          a_fc_ff[3:2] == mfml_pkg::FC_TYPE_MGMT) begin
         case (a_fc_ff[7:4])
            mfml_pkg::SUBTYPE_BEACON:   kind_in = mfml_pkg::KIND_BEACON;
            mfml_pkg::SUBTYPE_PROBE_RQ: kind_in = mfml_pkg::KIND_PROBE_REQ;
            mfml_pkg::SUBTYPE_PROBE_RS: kind_in = mfml_pkg::KIND_PROBE_RESP;
            mfml_pkg::SUBTYPE_DEAUTH:   kind_in = mfml_pkg::KIND_DEAUTH;
            default:                    kind_in = mfml_pkg::KIND_NONE;
         endcase
      end

      cap_in = (a_flen_ff < 12'(snap_length_ff)) ? a_flen_ff[7:0] : snap_length_ff;
      grown  = (LB+1)'(log_size_ff) + (LB+1)'(mfml_pkg::PCAP_RECORD_HDR)
               + (LB+1)'(cap_in);

      if (kind_in != mfml_pkg::KIND_NONE) begin
         case (kind_in)
            mfml_pkg::KIND_BEACON: beacons_in = beacons_ff + CB'(1);
            mfml_pkg::KIND_DEAUTH: begin
               deauths_in     = deauths_ff + CB'(1);
               last_deauth_in = a_now_ff;
            end
            default: probes_in = probes_ff + CB'(1);
         endcase
         if (log_ready_ff && !log_stopped_ff) begin
            if (grown > (LB+1)'(log_limit_ff)) begin
               log_stopped_in = 1'b1;
            end else begin
               log_size_in = grown[LB-1:0];
               written_in  = 1'b1;
            end
         end
      end else begin
         cap_in = '0;
      end

      // alert sees this item's deauth, wrap-around difference
      since_deauth = a_now_ff - last_deauth_in;
      alert_in = (last_deauth_in != 32'd0) && (since_deauth < 32'(alert_window_ff));

      if (log_stopped_in) begin
         status_in = mfml_pkg::LOG_STOPPED;
      end else if (log_ready_ff) begin
         status_in = mfml_pkg::LOG_ACTIVE;
      end else begin
         status_in = mfml_pkg::LOG_NOT_READY;
      end

      // remainder below 1000 fits 10 bits; x * 1000 = x*1024 - x*16 - x*8
      q_times_1000 = (32'(a_secs_ff) << 10) - (32'(a_secs_ff) << 4)
                     - (32'(a_secs_ff) << 3);
      rem_ms       = 10'(a_now_ff - q_times_1000);
      micros_in    = (20'(rem_ms) << 10) - (20'(rem_ms) << 4) - (20'(rem_ms) << 3);
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         alert_window_ff <= mfml_pkg::ALERT_WINDOW_RESET;
         snap_length_ff  <= mfml_pkg::SNAP_LENGTH_RESET;
         log_limit_ff    <= mfml_pkg::LOG_LIMIT_RESET;
         log_ready_ff    <= 1'b0;
         beacons_ff      <= '0;
         probes_ff       <= '0;
         deauths_ff      <= '0;
         last_deauth_ff  <= '0;
         log_size_ff     <= LB'(mfml_pkg::PCAP_FILE_HEADER);
         log_stopped_ff  <= 1'b0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               mfml_pkg::CSR_ALERT_WINDOW: alert_window_ff <= csr_write_data[19:0];
               mfml_pkg::CSR_SNAP_LENGTH:  snap_length_ff  <= csr_write_data[7:0];
               mfml_pkg::CSR_LOG_LIMIT:    log_limit_ff    <= csr_write_data;
               mfml_pkg::CSR_LOG_READY:    log_ready_ff    <= csr_write_data[0];
               default: ;
            endcase
         end
         if (a_load) begin
            a_valid_ff <= 1'b1;
         end else if (move) begin
            a_valid_ff <= 1'b0;
         end
         if (move) begin
            b_valid_ff     <= 1'b1;
            beacons_ff     <= beacons_in;
            probes_ff      <= probes_in;
            deauths_ff     <= deauths_in;
            last_deauth_ff <= last_deauth_in;
            log_size_ff    <= log_size_in;
            log_stopped_ff <= log_stopped_in;
         end else if (rsp_ready) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_op_ff   <= req_operation;
         a_mgmt_ff <= req_is_management;
         a_fc_ff   <= req_frame_control;
         a_flen_ff <= req_frame_length;
         a_now_ff  <= req_now_ms;
         a_secs_ff <= recip_product[mfml_pkg::MS_SHIFT+22:mfml_pkg::MS_SHIFT];
      end
      if (move) begin
         b_recorded_ff <= (kind_in != mfml_pkg::KIND_NONE);
         b_kind_ff     <= kind_in;
         b_cap_ff      <= cap_in;
         b_secs_ff     <= a_secs_ff;
         b_micros_ff   <= micros_in;
         b_alert_ff    <= alert_in;
         b_written_ff  <= written_in;
         b_status_ff   <= status_in;
      end
   end

   assign rsp_valid           = b_valid_ff;
   assign rsp_recorded        = b_recorded_ff;
   assign rsp_frame_kind      = b_kind_ff;
   assign rsp_captured_length = b_cap_ff;
   assign rsp_ts_seconds      = b_secs_ff;
   assign rsp_ts_micros       = b_micros_ff;
   assign rsp_beacon_total    = 32'(beacons_ff);
   assign rsp_probe_total     = 32'(probes_ff);
   assign rsp_deauth_total    = 32'(deauths_ff);
   assign rsp_alert_active    = b_alert_ff;
   assign rsp_log_written     = b_written_ff;
   assign rsp_log_status      = b_status_ff;

   // checks
   a_written_needs_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_log_written |-> rsp_recorded && rsp_log_status == mfml_pkg::LOG_ACTIVE)
      else $error("log write reported for an item that was not logged");

   a_stop_is_sticky: assert property (@(posedge clock) disable iff (reset)
      log_stopped_ff |=> log_stopped_ff)
      else $error("log stop cleared without reset");

   a_counts_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(beacons_ff) && $stable(probes_ff) && $stable(deauths_ff))
      else $error("counter changed with no item moving");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !rsp_ready |-> !move)
      else $error("result overwritten while stalled");

endmodule
